### rtl/ppa_pkg.sv
// Shared types and constants of the paired page allocator.
// Depends on nothing; the top, ppa_cell and ppa_chain import it.
package ppa_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_DUMP  = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BADADDR = 3'd1,
      ST_NOMEM   = 3'd2,
      ST_REFUSED = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_MEM_START = 1'b0,
      CSR_MEM_STOP  = 1'b1
   } csr_index_type;

   // Fixed field widths of the request and result beats
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 10;
   localparam int INDEX_W = 9;

   // Window register values after reset
   localparam logic [ADDR_W-1:0] MEM_START_RST = 32'h0010_0000;
   localparam logic [ADDR_W-1:0] MEM_STOP_RST  = 32'h0E00_0000;

   // Controls broadcast by the sequencer to the row of list cells
   typedef struct packed {
      logic srch_start;  // launch a search wave at the oldest cell
      logic rotate;      // every cell takes its right neighbor, ring closed
      logic append;      // the cell at the fill level takes the append data
   } chain_ctrl_type;

endpackage

### rtl/paired_page_allocator_top.sv
// Top level of the paired page allocator: sequencer, free stack RAM, list row.
// Depends on ppa_pkg, ppa_ram and ppa_chain.
//
// Page frame allocator working on pairs of pages. Free page numbers sit on a
// LIFO stack in a RAM of FREE_DEPTH entries; handed-out pages are logged,
// oldest first, in a row of ALLOC_SLOTS cells. One request is worked on at a
// time and gives one result beat; the next request is taken as soon as the
// result is parked in the output register. Free walks a search wave through
// the cell row once for each of its two pages, one cell per cycle. A dump
// rotates the whole row once. Refused or rejected requests go straight from
// decode to the result. The stack needs no clearing pass: entries below a
// low-water mark since the last init read as the window's start page plus
// their index, so reset and init take effect at once.
module paired_page_allocator_top #(
   parameter int FREE_DEPTH  = 16384,
   parameter int ALLOC_SLOTS = 512,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [ppa_pkg::ADDR_W-1:0]   req_page_address,
   input  logic [ppa_pkg::COUNT_W-1:0]  req_frame_count,
   input  logic [ppa_pkg::INDEX_W-1:0]  req_frame_index,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [ppa_pkg::ADDR_W-1:0]   rsp_page_address_res,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  ppa_pkg::csr_index_type       csr_index,
   input  logic [ppa_pkg::ADDR_W-1:0]   csr_wdata
);
   import ppa_pkg::*;

   localparam int N          = ALLOC_SLOTS;
   localparam int ACW        = $clog2(ALLOC_SLOTS + 1);
   localparam int IW         = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
   localparam int STW        = $clog2(ALLOC_SLOTS + 2);
   localparam int FIW        = $clog2(FREE_DEPTH);
   localparam int FCW        = $clog2(FREE_DEPTH + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PW         = ADDR_W - PAGE_SHIFT;
   localparam int SW         = (FIW > PW) ? FIW : PW;
   localparam int DW         = (ACW > COUNT_W) ? ACW : COUNT_W;
   localparam int XW         = ADDR_W + 1;

   // Stack contents after reset, worked out from the reset window
   localparam longint PB        = longint'(PAGE_BYTES);
   localparam longint RST_START = ((longint'(MEM_START_RST) + PB - 1) / PB) * PB;
   localparam longint RST_STOP  = longint'(MEM_STOP_RST);
   localparam longint RST_SPAN  = (RST_STOP > RST_START) ?
                                  ((RST_STOP - RST_START) / (2 * PB)) * 2 : 0;
   localparam longint FREE_CAP  = longint'(FREE_DEPTH) & ~longint'(1);
   localparam longint RST_PAGES = (RST_SPAN > FREE_CAP) ? FREE_CAP : RST_SPAN;
   localparam longint RST_BASE  = (RST_START / PB) % (longint'(1) << PW);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_DECODE    = 11'b000_0000_0010,
      S_INIT_CALC = 11'b000_0000_0100,
      S_INIT_SPAN = 11'b000_0000_1000,
      S_INIT_SET  = 11'b000_0001_0000,
      S_ALLOC_RD  = 11'b000_0010_0000,
      S_ALLOC_WR  = 11'b000_0100_0000,
      S_WAVE      = 11'b000_1000_0000,
      S_PUSH      = 11'b001_0000_0000,
      S_DUMP      = 11'b010_0000_0000,
      S_DONE      = 11'b100_0000_0000
   } state_type;

   // control registers
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  mem_start_ff, mem_start_in;
   logic [ADDR_W-1:0]  mem_stop_ff, mem_stop_in;
   logic [FCW-1:0]     fc_ff, fc_in;
   logic [FCW-1:0]     clean_ff, clean_in;
   logic [PW-1:0]      base_ff, base_in;
   logic [ACW-1:0]     ac_ff, ac_in;
   logic [STW-1:0]     step_ff, step_in;
   logic               second_ff, second_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   op_type             op_ff, op_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [PW-1:0]      key_ff, key_in;
   logic [FIW-1:0]     rptr_ff, rptr_in;
   logic [IW-1:0]      tgt_ff, tgt_in;
   logic [XW-1:0]      init_start_ff, init_start_in;
   logic [XW-1:0]      init_pages_ff, init_pages_in;
   status_type         res_st_ff, res_st_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   // datapath helpers
   chain_ctrl_type     ctrl;
   logic [PW-1:0]      app_data;
   logic [PW-1:0]      chain_head;
   logic               chain_found;
   logic               ram_we, ram_re;
   logic [FIW-1:0]     ram_waddr;
   logic [PW-1:0]      ram_wdata;
   logic [PW-1:0]      ram_rdata;
   logic [SW-1:0]      base_sum;
   logic [PW-1:0]      alloc_pg;
   logic               bad_addr;
   logic               dump_refused;
   logic [DW-1:0]      tgt_calc;
   logic [XW-1:0]      span;
   logic [FCW-1:0]     init_fc;
   logic               init_over;
   logic               req_accept;

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   // Free checks: page aligned and inside the window
   assign bad_addr = (addr_ff[PAGE_SHIFT-1:0] != '0) || (addr_ff < mem_start_ff) ||
                     (addr_ff >= mem_stop_ff);

   // Dump checks and the list position counted from the oldest entry
   assign dump_refused = (DW'(cnt_ff) > DW'(ac_ff)) || (DW'(idx_ff) >= DW'(cnt_ff));
   assign tgt_calc     = DW'(ac_ff) - DW'(1) - DW'(idx_ff);

   // Stack entries below the low-water mark still hold start page plus index
   assign base_sum = SW'(base_ff) + SW'(rptr_ff);
   assign alloc_pg = (FCW'(rptr_ff) < clean_ff) ? base_sum[PW-1:0] : ram_rdata;

   // Init window: whole pairs from the rounded-up start, capped at the stack
   assign span      = {1'b0, mem_stop_ff} - init_start_ff;
   assign init_over = (init_pages_ff > XW'(FREE_CAP));
   assign init_fc   = init_over ? FCW'(FREE_CAP) : init_pages_ff[FCW-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      mem_start_in  = mem_start_ff;
      mem_stop_in   = mem_stop_ff;
      fc_in         = fc_ff;
      clean_in      = clean_ff;
      base_in       = base_ff;
      ac_in         = ac_ff;
      step_in       = step_ff;
      second_in     = second_ff;
      found_in      = found_ff | chain_found;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      rptr_in       = rptr_ff;
      tgt_in        = tgt_ff;
      init_start_in = init_start_ff;
      init_pages_in = init_pages_ff;
      res_st_in     = res_st_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      ctrl          = '0;
      app_data      = alloc_pg;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = fc_ff[FIW-1:0];
      ram_wdata     = key_ff;

      // Drop the result beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MEM_START: mem_start_in = csr_wdata;
            CSR_MEM_STOP:  mem_stop_in  = csr_wdata;
            default:       mem_start_in = mem_start_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = op_type'(req_operation);
               addr_in  = req_page_address;
               cnt_in   = req_frame_count;
               idx_in   = req_frame_index;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_st_in   = ST_OK;
            res_addr_in = '0;
            step_in     = '0;
            unique case (op_ff)
               OP_INIT: begin
                  state_in = S_INIT_CALC;
               end
               OP_ALLOC: begin
                  if (fc_ff < FCW'(2)) begin
                     res_st_in = ST_NOMEM;
                     state_in  = S_DONE;
                  end else if (ac_ff >= ACW'(N)) begin
                     res_st_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     rptr_in  = FIW'(fc_ff - FCW'(2));
                     state_in = S_ALLOC_RD;
                  end
               end
               OP_FREE: begin
                  if (bad_addr) begin
                     res_st_in = ST_BADADDR;
                     state_in  = S_DONE;
                  end else if (fc_ff > FCW'(FREE_DEPTH - 2)) begin
                     res_st_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     key_in    = addr_ff[ADDR_W-1:PAGE_SHIFT];
                     second_in = 1'b0;
                     state_in  = S_WAVE;
                  end
               end
               OP_DUMP: begin
                  if (dump_refused) begin
                     res_st_in = ST_REFUSED;
                     state_in  = S_DONE;
                  end else begin
                     tgt_in   = tgt_calc[IW-1:0];
                     state_in = S_DUMP;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end

         S_INIT_CALC: begin
            init_start_in = ({1'b0, mem_start_ff} + XW'(PAGE_BYTES - 1)) &
                            ~XW'(PAGE_BYTES - 1);
            state_in      = S_INIT_SPAN;
         end

         S_INIT_SPAN: begin
            if ({1'b0, mem_stop_ff} > init_start_ff) begin
               init_pages_in = (span >> (PAGE_SHIFT + 1)) << 1;
            end else begin
               init_pages_in = '0;
            end
            state_in = S_INIT_SET;
         end

         S_INIT_SET: begin
            fc_in     = init_fc;
            clean_in  = init_fc;
            base_in   = init_start_ff[ADDR_W-1:PAGE_SHIFT];
            ac_in     = '0;
            res_st_in = init_over ? ST_FULL : ST_OK;
            state_in  = S_DONE;
         end

         S_ALLOC_RD: begin
            ram_re   = 1'b1;
            state_in = S_ALLOC_WR;
         end

         S_ALLOC_WR: begin
            // pop two, log and hand out the second one popped
            ctrl.append = 1'b1;
            app_data    = alloc_pg;
            ac_in       = ac_ff + ACW'(1);
            fc_in       = fc_ff - FCW'(2);
            res_addr_in = {alloc_pg, {PAGE_SHIFT{1'b0}}};
            state_in    = S_DONE;
         end

         S_WAVE: begin
            // launch a search wave, then wait for it to leave the row
            if (step_ff == '0) begin
               ctrl.srch_start = 1'b1;
               found_in        = 1'b0;
            end
            step_in = step_ff + STW'(1);
            if (step_ff == STW'(N + 1)) begin
               if (found_ff) begin
                  ac_in = ac_ff - ACW'(1);
               end
               step_in  = '0;
               state_in = S_PUSH;
            end
         end

         S_PUSH: begin
            ram_we    = 1'b1;
            ram_waddr = fc_ff[FIW-1:0];
            ram_wdata = key_ff;
            fc_in     = fc_ff + FCW'(1);
            if (fc_ff < clean_ff) begin
               clean_in = fc_ff;
            end
            if (!second_ff) begin
               key_in    = key_ff + PW'(1);
               second_in = 1'b1;
               state_in  = S_WAVE;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DUMP: begin
            // rotate the ring once; the wanted entry passes the head cell
            ctrl.rotate = 1'b1;
            if (step_ff == STW'(tgt_ff)) begin
               res_addr_in = {chain_head, {PAGE_SHIFT{1'b0}}};
            end
            if (step_ff == STW'(N - 1)) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               step_in = step_ff + STW'(1);
            end
         end

         S_DONE: begin
            // park the result beat in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_st_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mem_start_ff <= MEM_START_RST;
         mem_stop_ff  <= MEM_STOP_RST;
         fc_ff        <= FCW'(RST_PAGES);
         clean_ff     <= FCW'(RST_PAGES);
         base_ff      <= PW'(RST_BASE);
         ac_ff        <= '0;
         step_ff      <= '0;
         second_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mem_start_ff <= mem_start_in;
         mem_stop_ff  <= mem_stop_in;
         fc_ff        <= fc_in;
         clean_ff     <= clean_in;
         base_ff      <= base_in;
         ac_ff        <= ac_in;
         step_ff      <= step_in;
         second_ff    <= second_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      rptr_ff       <= rptr_in;
      tgt_ff        <= tgt_in;
      init_start_ff <= init_start_in;
      init_pages_ff <= init_pages_in;
      res_st_ff     <= res_st_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_page_address_res = rsp_addr_ff;

   // Free page stack
   ppa_ram #(
      .WIDTH (PW),
      .DEPTH (FREE_DEPTH)
   ) u_free_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rptr_ff),
      .rd_data (ram_rdata)
   );

   // Allocated page list
   ppa_chain #(
      .N   (N),
      .PW  (PW),
      .ACW (ACW)
   ) u_alloc_list (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .count     (ac_ff),
      .key       (key_ff),
      .app_data  (app_data),
      .head_data (chain_head),
      .found     (chain_found)
   );

   // The stack never holds more pages than it has entries
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= FCW'(FREE_DEPTH))
      else $error("free count beyond stack depth");

   // A removal can only come out of the row while pages are logged
   a_found_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAVE && chain_found) |-> (ac_ff != '0))
      else $error("list removal with empty log");

   // An allocation pops exactly two stack entries
   a_alloc_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_WR) |=> (fc_ff == $past(fc_ff) - FCW'(2)))
      else $error("allocation did not pop a pair");

endmodule

### rtl/ppa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the free page stack.
module ppa_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 16384
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ppa_cell.sv
// One cell of the allocated-page list: holds one page number and passes
// search and shift tokens to its right neighbor. Depends on ppa_pkg.
module ppa_cell #(
   parameter int INDEX = 0,
   parameter int PW    = 20,
   parameter int ACW   = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppa_pkg::chain_ctrl_type ctrl,
   input  logic [ACW-1:0]          count,
   input  logic [PW-1:0]           key,
   input  logic [PW-1:0]           app_data,
   input  logic [PW-1:0]           nbr_data,
   input  logic                    srch_in,
   input  logic                    shf_in,
   output logic [PW-1:0]           data_out,
   output logic                    srch_out,
   output logic                    shf_out
);
   import ppa_pkg::*;

   logic [PW-1:0] data_ff, data_in;
   logic          srch_ff, shf_ff;
   logic          live, hit, take;

   // Cell holds a logged page when it sits below the fill level
   assign live = (ACW'(INDEX) < count);
   assign hit  = srch_ff & live & (data_ff == key);
   assign take = ctrl.rotate | shf_ff | hit;

   // Pick the next entry: append, shift down from the right, or hold
   always_comb begin
      data_in = data_ff;
      if (ctrl.append && (count == ACW'(INDEX))) begin
         data_in = app_data;
      end else if (take) begin
         data_in = nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Advance the tokens one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         srch_ff <= 1'b0;
         shf_ff  <= 1'b0;
      end else begin
         srch_ff <= srch_in;
         shf_ff  <= shf_in;
      end
   end

   // A search stops at the first live match, which turns into a shift wave, or at the fill level
   assign srch_out = srch_ff & live & ~hit;
   assign shf_out  = shf_ff | hit;
   assign data_out = data_ff;

endmodule

### rtl/ppa_chain.sv
// Row of list cells, oldest entry at cell 0, closed into a ring for rotation.
// Depends on ppa_pkg and ppa_cell.
module ppa_chain #(
   parameter int N   = 512,
   parameter int PW  = 20,
   parameter int ACW = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppa_pkg::chain_ctrl_type ctrl,
   input  logic [ACW-1:0]          count,
   input  logic [PW-1:0]           key,
   input  logic [PW-1:0]           app_data,
   output logic [PW-1:0]           head_data,
   output logic                    found
);
   import ppa_pkg::*;

   logic [PW-1:0] data   [N];
   logic          srch_o [N];
   logic          shf_o  [N];

   // Wire cells in a row: tokens go right, data moves left
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [PW-1:0] nbr;
      logic          s_in, h_in;

      if (i == N - 1) begin : g_last
         assign nbr = data[0];
      end else begin : g_mid
         assign nbr = data[i+1];
      end

      if (i == 0) begin : g_first
         assign s_in = ctrl.srch_start;
         assign h_in = 1'b0;
      end else begin : g_rest
         assign s_in = srch_o[i-1];
         assign h_in = shf_o[i-1];
      end

      ppa_cell #(
         .INDEX (i),
         .PW    (PW),
         .ACW   (ACW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .count    (count),
         .key      (key),
         .app_data (app_data),
         .nbr_data (nbr),
         .srch_in  (s_in),
         .shf_in   (h_in),
         .data_out (data[i]),
         .srch_out (srch_o[i]),
         .shf_out  (shf_o[i])
      );
   end

   // A shift wave leaving the last cell means the key was removed
   assign found     = shf_o[N-1];
   assign head_data = data[0];

endmodule
